// File: design/bb3_pkg.sv
// shared types and constants for the 3x3 rgb box blur
// used by every module of the block; no dependencies
package bb3_pkg;

    localparam int ROW_W  = 14;
    localparam int COL_W  = 12;
    localparam int CHAN_W = 8;
    localparam int PIX_W  = 3 * CHAN_W;
    localparam int SUM_W  = 12;
    localparam int WID_W  = 13;
    localparam int HGT_W  = 14;
    localparam int COL_LIMIT = 4096;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [WID_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [HGT_W-1:0] HEIGHT_RESET = 14'd480;

    // floor(s / 9) = (s * 3641) >> 15 for every s below 4096
    localparam logic [SUM_W-1:0] DIV9_MUL = 12'd3641;
    localparam int DIV9_SHIFT = 15;
    localparam int PROD_W = 2 * SUM_W;

    localparam int OUT_DATA_W = 56;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [SUM_W-1:0] sum_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             row_end;
        logic             last_row;
    } item_ctl_t;

    typedef struct packed {
        item_ctl_t ctl;
        sum_t      sum_b;
        sum_t      sum_g;
        sum_t      sum_r;
        pixel_t    centre;
        pixel_t    right;
        pixel_t    pix;
    } win_out_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        pixel_t           pix;
        logic             frame_end;
    } result_t;

endpackage

// File: design/box_blur_3x3_rgb.sv
// 3x3 rgb box blur top level: config registers, row and column counters
// path: input stage, window and sum stages, result registers, then the output register
// throughput: one pixel a cycle while the result stream is ready; a pixel with two or three results
// holds the input until its extra results are sent (row ends and the last row)
// reset: counters, window and stream valids clear, sizes go to 640 x 480; line stores are not cleared
// uses bb3_pkg, bb3_line_store, bb3_window and bb3_emit
module box_blur_3x3_rgb
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // in_red, in_green, in_blue
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_row, out_col, out_red, out_green, out_blue, pad
    output logic                  m_tlast    // frame_end
);

    localparam int COL_CAP = (MAX_WIDTH < COL_LIMIT) ? MAX_WIDTH : COL_LIMIT;
    localparam int ADDR_W  = $clog2(COL_CAP);
    localparam logic [WID_W-1:0] COL_CAP_V = WID_W'(COL_CAP);

    logic [WID_W-1:0] image_width_reg;
    logic [HGT_W-1:0] image_height_reg;
    logic [ROW_W-1:0] row_count_reg;
    logic [COL_W-1:0] col_count_reg;
    logic             s1_valid_reg;
    item_ctl_t        s1_ctl_reg;
    pixel_t           s1_pix_reg;

    logic [WID_W-1:0] width_eff;
    logic [WID_W-1:0] width_last;
    logic [HGT_W-1:0] height_last;
    logic             row_end;
    logic             last_row;
    logic             s_fire;
    logic             s1_fire;
    logic             win_ready;
    pixel_t           older;
    pixel_t           newer;
    logic             win_valid;
    win_out_t         win_data;
    logic             emit_ready;

    always_comb begin
        if (image_width_reg == '0) begin
            width_eff = WID_W'(1);
        end else if (image_width_reg > COL_CAP_V) begin
            width_eff = COL_CAP_V;
        end else begin
            width_eff = image_width_reg;
        end
    end

    assign width_last  = width_eff - WID_W'(1);
    assign height_last = (image_height_reg == '0) ? '0 : image_height_reg - HGT_W'(1);
    assign row_end     = {1'b0, col_count_reg} >= width_last;
    assign last_row    = row_count_reg >= height_last;

    assign s_tready = !s1_valid_reg || win_ready;
    assign s_fire   = s_tvalid && s_tready;
    assign s1_fire  = s1_valid_reg && win_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[WID_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[HGT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s_fire) begin
                if (row_end) begin
                    col_count_reg <= '0;
                    row_count_reg <= last_row ? '0 : row_count_reg + ROW_W'(1);
                end else begin
                    col_count_reg <= col_count_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_ctl_reg.row      <= row_count_reg;
            s1_ctl_reg.col      <= col_count_reg;
            s1_ctl_reg.row_end  <= row_end;
            s1_ctl_reg.last_row <= last_row;
            s1_pix_reg          <= s_tdata;
        end
    end

    bb3_line_store #(
        .DEPTH  (COL_CAP),
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (s_fire),
        .rd_addr (col_count_reg[ADDR_W-1:0]),
        .wr_en   (s1_fire),
        .wr_addr (s1_ctl_reg.col[ADDR_W-1:0]),
        .wr_pix  (s1_pix_reg),
        .older   (older),
        .newer   (newer)
    );

    bb3_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid_reg),
        .in_ready  (win_ready),
        .in_ctl    (s1_ctl_reg),
        .in_older  (older),
        .in_newer  (newer),
        .in_pix    (s1_pix_reg),
        .out_valid (win_valid),
        .out_ready (emit_ready),
        .out_data  (win_data)
    );

    bb3_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (win_valid),
        .in_ready (emit_ready),
        .in_data  (win_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: design/bb3_line_store.sv
// two line stores held in one synchronous memory, one entry per column
// read when a pixel is taken in, written back as it leaves the first stage; uses bb3_pkg
module bb3_line_store
    import bb3_pkg::*;
#(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  pixel_t            wr_pix,
    output pixel_t            older,
    output pixel_t            newer
);

    logic [2*PIX_W-1:0] mem [DEPTH];
    logic [2*PIX_W-1:0] rd_data_reg;
    logic [2*PIX_W-1:0] byp_data_reg;
    logic               byp_hit_reg;
    logic [2*PIX_W-1:0] cur;
    logic [2*PIX_W-1:0] wr_data;

    // newer row in the upper half, older row in the lower half
    assign cur     = byp_hit_reg ? byp_data_reg : rd_data_reg;
    assign older   = cur[PIX_W-1:0];
    assign newer   = cur[2*PIX_W-1:PIX_W];
    assign wr_data = {wr_pix, newer};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            byp_hit_reg  <= wr_en && (wr_addr == rd_addr);
            byp_data_reg <= wr_data;
        end
    end

endmodule

// File: design/bb3_window.sv
// 3x3 window registers and the per-channel nine-pixel sums
// holds the window stage and the sum stage; uses bb3_pkg
module bb3_window
    import bb3_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  item_ctl_t in_ctl,
    input  pixel_t    in_older,
    input  pixel_t    in_newer,
    input  pixel_t    in_pix,
    output logic      out_valid,
    input  logic      out_ready,
    output win_out_t  out_data
);

    pixel_t    win_reg [9];
    logic      s2_valid_reg;
    item_ctl_t s2_ctl_reg;
    pixel_t    s2_pix_reg;
    logic      s3_valid_reg;
    win_out_t  s3_data_reg;
    logic      ld3;
    logic      in_fire;
    logic      s2_fire;
    sum_t      sum_r;
    sum_t      sum_g;
    sum_t      sum_b;

    assign ld3      = !s3_valid_reg || out_ready;
    assign in_ready = !s2_valid_reg || ld3;
    assign in_fire  = in_valid && in_ready;
    assign s2_fire  = s2_valid_reg && ld3;

    always_comb begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int i = 0; i < 9; i++) begin
            sum_r = sum_r + SUM_W'(win_reg[i][CHAN_W-1:0]);
            sum_g = sum_g + SUM_W'(win_reg[i][2*CHAN_W-1:CHAN_W]);
            sum_b = sum_b + SUM_W'(win_reg[i][3*CHAN_W-1:2*CHAN_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (in_fire) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i*3]   <= win_reg[i*3+1];
                win_reg[i*3+1] <= win_reg[i*3+2];
            end
            win_reg[2] <= in_older;
            win_reg[5] <= in_newer;
            win_reg[8] <= in_pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                s2_valid_reg <= in_valid;
            end
            if (ld3) begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s2_ctl_reg <= in_ctl;
            s2_pix_reg <= in_pix;
        end
        if (s2_fire) begin
            s3_data_reg.ctl    <= s2_ctl_reg;
            s3_data_reg.sum_r  <= sum_r;
            s3_data_reg.sum_g  <= sum_g;
            s3_data_reg.sum_b  <= sum_b;
            s3_data_reg.centre <= win_reg[4];
            s3_data_reg.right  <= win_reg[5];
            s3_data_reg.pix    <= s2_pix_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_data_reg;

endmodule

// File: design/bb3_emit.sv
// divide by nine, build up to three results per pixel and send them one a cycle
// while the result stream is ready; ends in the output register of the result stream; uses bb3_pkg
module bb3_emit
    import bb3_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  win_out_t              in_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    result_t    res_reg [3];
    logic [2:0] mask_reg;
    logic       m_valid_reg;
    result_t    m_res_reg;
    logic       out_load;
    logic       in_fire;
    logic [1:0] pick;
    logic [2:0] mask_left;
    logic [PROD_W-1:0] prod_r;
    logic [PROD_W-1:0] prod_g;
    logic [PROD_W-1:0] prod_b;
    pixel_t     blurred;
    pixel_t     first_pix;
    logic       first_ok;
    item_ctl_t  ctl;

    assign ctl = in_data.ctl;

    assign prod_r = PROD_W'(in_data.sum_r) * PROD_W'(DIV9_MUL);
    assign prod_g = PROD_W'(in_data.sum_g) * PROD_W'(DIV9_MUL);
    assign prod_b = PROD_W'(in_data.sum_b) * PROD_W'(DIV9_MUL);
    assign blurred = {prod_b[DIV9_SHIFT+CHAN_W-1:DIV9_SHIFT],
                      prod_g[DIV9_SHIFT+CHAN_W-1:DIV9_SHIFT],
                      prod_r[DIV9_SHIFT+CHAN_W-1:DIV9_SHIFT]};
    // interior only from the third row and third column on
    assign first_ok  = (ctl.row >= ROW_W'(2)) && (ctl.col >= COL_W'(2));
    assign first_pix = first_ok ? blurred : in_data.centre;

    always_comb begin
        if (mask_reg[0]) begin
            pick = 2'd0;
        end else if (mask_reg[1]) begin
            pick = 2'd1;
        end else begin
            pick = 2'd2;
        end
    end

    assign mask_left = mask_reg & ~(3'b001 << pick);
    assign out_load  = !m_valid_reg || m_tready;
    assign in_ready  = (mask_reg == 3'b000) || (out_load && (mask_left == 3'b000));
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= 3'b000;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                mask_reg[0] <= (ctl.row != '0) && (ctl.col != '0);
                mask_reg[1] <= (ctl.row != '0) && ctl.row_end;
                mask_reg[2] <= ctl.last_row;
            end else if (out_load && (mask_reg != 3'b000)) begin
                mask_reg <= mask_left;
            end
            if (out_load) begin
                m_valid_reg <= (mask_reg != 3'b000);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            res_reg[0].row       <= ctl.row - ROW_W'(1);
            res_reg[0].col       <= ctl.col - COL_W'(1);
            res_reg[0].pix       <= first_pix;
            res_reg[0].frame_end <= 1'b0;
            res_reg[1].row       <= ctl.row - ROW_W'(1);
            res_reg[1].col       <= ctl.col;
            res_reg[1].pix       <= in_data.right;
            res_reg[1].frame_end <= 1'b0;
            res_reg[2].row       <= ctl.row;
            res_reg[2].col       <= ctl.col;
            res_reg[2].pix       <= in_data.pix;
            res_reg[2].frame_end <= ctl.row_end;
        end
        if (out_load && (mask_reg != 3'b000)) begin
            m_res_reg <= res_reg[pick];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_res_reg.pix, m_res_reg.col, m_res_reg.row};
    assign m_tlast  = m_res_reg.frame_end;

endmodule

// File: dv/box_blur_3x3_rgb_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for box_blur_3x3_rgb: directed and random rgb frames,
// each result checked against a built-in 3x3 blur predictor held in a scoreboard class
// needs bb3_pkg and the box_blur_3x3_rgb design sources
module box_blur_3x3_rgb_tb;
    import bb3_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 90;

    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 2'd3;

    localparam pixel_t SQUARE [9] = '{
        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
        24'hFFFFFF, 24'hFE00FF, 24'hFFFFFF,
        24'hFFFFFF, 24'hFFFFFF, 24'h0000FF
    };

    class blur_scoreboard;
        logic [WID_W-1:0] width_reg;
        logic [HGT_W-1:0] height_reg;
        pixel_t           older_row [COL_LIMIT];
        pixel_t           newer_row [COL_LIMIT];
        pixel_t           win [9];
        logic [ROW_W-1:0] row_cnt;
        logic [COL_W-1:0] col_cnt;
        result_t          due [$];
        int               errors;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            row_cnt    = '0;
            col_cnt    = '0;
            errors     = 0;
            foreach (win[i]) win[i] = '0;
            foreach (older_row[i]) begin
                older_row[i] = '0;
                newer_row[i] = '0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_IMAGE_WIDTH) begin
                width_reg = value[WID_W-1:0];
            end else if (idx == REG_IMAGE_HEIGHT) begin
                height_reg = value[HGT_W-1:0];
            end
        endfunction

        function int cols_per_row();
            int w;
            w = width_reg;
            if (w < 1) w = 1;
            if (w > COL_LIMIT) w = COL_LIMIT;
            return w;
        endfunction

        function pixel_t box_mean();
            int unsigned total;
            pixel_t      res;
            for (int k = 0; k < 3; k++) begin
                total = 0;
                for (int i = 0; i < 9; i++) total += win[i][8*k +: 8];
                res[8*k +: 8] = 8'(total / 9);
            end
            return res;
        endfunction

        function void take_pixel(pixel_t px);
            int      w;
            int      h;
            pixel_t  up2;
            pixel_t  up1;
            logic    row_end;
            logic    last_row;
            result_t r;
            w   = cols_per_row();
            h   = (height_reg == 0) ? 1 : height_reg;
            up2 = older_row[col_cnt];
            up1 = newer_row[col_cnt];
            for (int i = 0; i < 3; i++) begin
                win[i*3]   = win[i*3+1];
                win[i*3+1] = win[i*3+2];
            end
            win[2] = up2;
            win[5] = up1;
            win[8] = px;
            older_row[col_cnt] = up1;
            newer_row[col_cnt] = px;
            row_end  = col_cnt >= w - 1;
            last_row = row_cnt >= h - 1;

            if (row_cnt >= 1 && col_cnt >= 1) begin
                r.row       = row_cnt - ROW_W'(1);
                r.col       = col_cnt - COL_W'(1);
                r.pix       = (row_cnt >= 2 && col_cnt >= 2) ? box_mean() : win[4];
                r.frame_end = 1'b0;
                due.push_back(r);
            end
            if (row_cnt >= 1 && row_end) begin
                r.row       = row_cnt - ROW_W'(1);
                r.col       = col_cnt;
                r.pix       = win[5];
                r.frame_end = 1'b0;
                due.push_back(r);
            end
            if (last_row) begin
                r.row       = row_cnt;
                r.col       = col_cnt;
                r.pix       = px;
                r.frame_end = row_end;
                due.push_back(r);
            end

            if (row_end) begin
                col_cnt = '0;
                row_cnt = last_row ? '0 : row_cnt + 1'b1;
            end else begin
                col_cnt = col_cnt + 1'b1;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic last);
            result_t want;
            if (due.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result row %0d col %0d rgb %06h last %0b",
                         $time, data[13:0], data[25:14], data[49:26], last);
                return;
            end
            want = due.pop_front();
            if (data[13:0] !== want.row || data[25:14] !== want.col || data[49:26] !== want.pix
                    || data[55:50] !== 6'd0 || last !== want.frame_end) begin
                errors++;
                $display("%0t ns: mismatch, expected row %0d col %0d rgb %06h pad 0 last %0b",
                         $time, want.row, want.col, want.pix, want.frame_end);
                $display("%0t ns:      got row %0d col %0d rgb %06h pad %0h last %0b",
                         $time, data[13:0], data[25:14], data[49:26], data[55:50], last);
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    blur_scoreboard sb = new();
    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    int stall_left   = 0;
    int quiet_cycles = 0;
    int random_items = 0;

    box_blur_3x3_rgb dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) sb.set_reg(cfg_addr, cfg_wdata);
            if (s_tvalid && s_tready) sb.take_pixel(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
        end
    end

    // result side back-pressure: mostly short stalls, now and then a long one
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else if (stalls_on && $urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(1, 3);
            stall_left--;
            m_tready = 1'b0;
        end else begin
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic pixel_t random_pixel();
        pixel_t px;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 6))
                0:       px[8*k +: 8] = 8'h00;
                1:       px[8*k +: 8] = 8'hFF;
                default: px[8*k +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        return px;
    endfunction

    function automatic int gap_len();
        int pick;
        if (!gaps_on) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // called at a falling edge; returns at the falling edge after the request is taken
    task automatic send_pixel(pixel_t px);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = px;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // hold off requests until every owed pixel is out and the pipe has emptied
    task automatic settle();
        s_tvalid = 1'b0;
        while (sb.due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic run_frame();
        int pick;
        int twist_at;
        int sent;
        gaps_on   = $urandom_range(0, 3) != 0;
        stalls_on = $urandom_range(0, 3) != 0;
        pick = $urandom_range(0, 9);
        if (pick == 0)      write_reg(REG_IMAGE_WIDTH, 14'd0);
        else if (pick == 1) write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(7, 16)));
        else                write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(1, 6)));
        write_reg(REG_IMAGE_HEIGHT,
                  CFG_DATA_W'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5)));
        twist_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : -1;
        sent = 0;
        do begin
            if (sent == twist_at) begin
                // narrowing or a new height mid-frame; widening would read unwritten columns
                settle();
                if ($urandom_range(0, 1) == 0)
                    write_reg(REG_IMAGE_WIDTH,
                              CFG_DATA_W'($urandom_range(0, sb.cols_per_row())));
                else
                    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 6)));
            end
            send_pixel(random_pixel());
            sent++;
        end while (sb.row_cnt != 0 || sb.col_cnt != 0);
        settle();
        random_items += sent;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // start under the reset size, then cut to one short row mid-frame
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        settle();
        write_reg(REG_IMAGE_WIDTH, 14'd3);
        write_reg(REG_IMAGE_HEIGHT, 14'd1);
        send_pixel(24'h80FF01);
        settle();

        // smallest frame with a blurred centre, near-saturated sums
        write_reg(REG_IMAGE_HEIGHT, 14'd3);
        foreach (SQUARE[i]) send_pixel(SQUARE[i]);
        settle();

        // indexes past the register list must change nothing
        write_reg(REG_NONE_LO, 14'h3FFF);
        write_reg(REG_NONE_HI, 14'h0000);
        write_reg(REG_NONE_LO, 14'h0000);

        // zero sizes act as one
        write_reg(REG_IMAGE_WIDTH, 14'd0);
        write_reg(REG_IMAGE_HEIGHT, 14'd0);
        send_pixel(random_pixel());
        settle();
        write_reg(REG_IMAGE_HEIGHT, 14'd2);
        send_pixel(random_pixel());
        send_pixel(random_pixel());
        settle();

        // single row passes straight through
        write_reg(REG_IMAGE_WIDTH, 14'd4);
        write_reg(REG_IMAGE_HEIGHT, 14'd1);
        repeat (4) send_pixel(random_pixel());
        settle();

        // largest sizes, then shrink both mid-frame so the current row and frame end early
        write_reg(REG_IMAGE_WIDTH, 14'h3FFF);
        write_reg(REG_IMAGE_HEIGHT, 14'h3FFF);
        repeat (3) send_pixel(random_pixel());
        settle();
        write_reg(REG_IMAGE_WIDTH, 14'd3);
        write_reg(REG_IMAGE_HEIGHT, 14'd2);
        repeat (4) send_pixel(random_pixel());
        settle();

        // bit 13 of the width is dropped, leaving two columns
        write_reg(REG_IMAGE_WIDTH, 14'h2002);
        write_reg(REG_IMAGE_HEIGHT, 14'd1);
        repeat (2) send_pixel(random_pixel());
        settle();

        while (random_items < RANDOM_ITEMS) run_frame();

        settle();
        if (sb.errors == 0 && sb.due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
